// ===== rtl/core/jts_pkg.sv =====
// Package for the JPEG table and size scanner: widths, marker codes,
// scan phases, status codes and the result record type. No dependencies.
package jts_pkg;

   // Byte positions saturate at the frame limit, which needs one extra bit.
   localparam int unsigned MAX_FRAME_BYTES = 1048576;
   localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int unsigned OFS_W = 21;
   localparam int unsigned DIM_W = 16;
   localparam int unsigned STAT_W = 3;

   localparam logic [POS_W-1:0] FRAME_LIMIT = POS_W'(MAX_FRAME_BYTES);

   // Marker bytes: prefix then code.
   localparam logic [7:0] MARK_PREFIX = 8'hFF;
   localparam logic [7:0] DQT_CODE = 8'hDB;
   localparam logic [7:0] SOF0_CODE = 8'hC0;

   // Segment lengths below this are treated as this.
   localparam logic [15:0] MIN_SEG_LEN = 16'd4;

   // Scan phases.
   localparam logic [1:0] PH_SEEK_FIRST = 2'd0;
   localparam logic [1:0] PH_SEEK_SECOND = 2'd1;
   localparam logic [1:0] PH_SEEK_SOF = 2'd2;
   localparam logic [1:0] PH_SOF_FOUND = 2'd3;

   // Result status codes.
   localparam logic [STAT_W-1:0] ST_OK = 3'd0;
   localparam logic [STAT_W-1:0] ST_NO_FIRST = 3'd1;
   localparam logic [STAT_W-1:0] ST_NO_SECOND = 3'd2;
   localparam logic [STAT_W-1:0] ST_NO_SIZE = 3'd3;
   localparam logic [STAT_W-1:0] ST_TOO_LONG = 3'd4;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [OFS_W-1:0]  first_table_offset;
      logic [OFS_W-1:0]  second_table_offset;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
   } result_type;

endpackage

// ===== rtl/core/jts_req_if.sv =====
// Input channel of the scanner: one file byte and a last-byte flag per transaction.
// No dependencies.
interface jts_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

// ===== rtl/core/jts_rsp_if.sv =====
// Result channel of the scanner: status, table offsets and image size per transaction.
// Depends on jts_pkg for field widths.
interface jts_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [jts_pkg::STAT_W-1:0] status;
   logic [jts_pkg::OFS_W-1:0]  first_table_offset;
   logic [jts_pkg::OFS_W-1:0]  second_table_offset;
   logic [jts_pkg::DIM_W-1:0]  image_width;
   logic [jts_pkg::DIM_W-1:0]  image_height;

   modport source (output valid, output status, output first_table_offset,
                   output second_table_offset, output image_width, output image_height,
                   input ready);
   modport sink (input valid, input status, input first_table_offset,
                 input second_table_offset, input image_width, input image_height,
                 output ready);
endinterface

// ===== rtl/core/jts_scan.sv =====
// Per-byte marker scan: position counter, marker search, length and size capture,
// and the end-of-frame result. Depends on jts_pkg.
module jts_scan (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 take,
   input  logic [7:0]           data_byte,
   input  logic                 last_byte,
   output logic                 result_valid,
   output jts_pkg::result_type  result
);

   logic [jts_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [7:0]                prev_byte_ff, prev_byte_in;
   logic                      prev_valid_ff, prev_valid_in;
   logic [1:0]                phase_ff, phase_in;
   logic [jts_pkg::POS_W-1:0] resume_ff, resume_in;
   logic [jts_pkg::POS_W-1:0] marker_ff, marker_in;
   logic [7:0]                len_high_ff, len_high_in;
   logic [jts_pkg::OFS_W-1:0] first_ofs_ff, first_ofs_in;
   logic [jts_pkg::OFS_W-1:0] second_ofs_ff, second_ofs_in;
   logic [jts_pkg::DIM_W-1:0] width_ff, width_in;
   logic [jts_pkg::DIM_W-1:0] height_ff, height_in;

   logic                      too_long;
   logic [jts_pkg::POS_W-1:0] cand;
   logic                      pair_ok;
   logic                      dqt_hit;
   logic                      sof_hit;
   logic                      len_hi_hit;
   logic                      len_lo_hit;
   logic [15:0]               seg_len;
   logic [15:0]               seg_len_clamped;
   logic [jts_pkg::POS_W-1:0] cand_ofs;

   // Decode the current byte against the scan state
   always_comb begin
      too_long = pos_ff >= jts_pkg::FRAME_LIMIT;
      cand = pos_ff - jts_pkg::POS_W'(1);
      pair_ok = prev_valid_ff && (cand >= resume_ff);
      dqt_hit = pair_ok && (prev_byte_ff == jts_pkg::MARK_PREFIX)
                && (data_byte == jts_pkg::DQT_CODE);
      sof_hit = pair_ok && (prev_byte_ff == jts_pkg::MARK_PREFIX)
                && (data_byte == jts_pkg::SOF0_CODE);
      len_hi_hit = pos_ff == (marker_ff + jts_pkg::POS_W'(2));
      len_lo_hit = pos_ff == (marker_ff + jts_pkg::POS_W'(3));
      seg_len = {len_high_ff, data_byte};
      seg_len_clamped = (seg_len < jts_pkg::MIN_SEG_LEN) ? jts_pkg::MIN_SEG_LEN : seg_len;
      cand_ofs = cand + jts_pkg::POS_W'(5);
   end

   // Advance the scan state for one byte
   always_comb begin
      pos_in = pos_ff;
      prev_byte_in = prev_byte_ff;
      prev_valid_in = prev_valid_ff;
      phase_in = phase_ff;
      resume_in = resume_ff;
      marker_in = marker_ff;
      len_high_in = len_high_ff;
      first_ofs_in = first_ofs_ff;
      second_ofs_in = second_ofs_ff;
      width_in = width_ff;
      height_in = height_ff;

      if (!too_long) begin
         pos_in = pos_ff + jts_pkg::POS_W'(1);
         prev_byte_in = data_byte;
         prev_valid_in = 1'b1;
         case (phase_ff)
            jts_pkg::PH_SEEK_FIRST: begin
               if (dqt_hit) begin
                  marker_in = cand;
                  first_ofs_in = jts_pkg::OFS_W'(cand_ofs);
                  resume_in = cand + jts_pkg::POS_W'(4);
                  phase_in = jts_pkg::PH_SEEK_SECOND;
               end
            end
            jts_pkg::PH_SEEK_SECOND, jts_pkg::PH_SEEK_SOF: begin
               if (len_hi_hit) begin
                  len_high_in = data_byte;
               end else if (len_lo_hit) begin
                  resume_in = marker_ff + jts_pkg::POS_W'(seg_len_clamped);
               end else if (phase_ff == jts_pkg::PH_SEEK_SECOND && dqt_hit) begin
                  marker_in = cand;
                  second_ofs_in = jts_pkg::OFS_W'(cand_ofs);
                  resume_in = cand + jts_pkg::POS_W'(4);
                  phase_in = jts_pkg::PH_SEEK_SOF;
               end else if (phase_ff == jts_pkg::PH_SEEK_SOF && sof_hit) begin
                  marker_in = cand;
                  phase_in = jts_pkg::PH_SOF_FOUND;
               end
            end
            default: begin
               // Size bytes: height at +5/+6, width at +7/+8, big endian
               if (pos_ff == marker_ff + jts_pkg::POS_W'(5)
                   || pos_ff == marker_ff + jts_pkg::POS_W'(6)) begin
                  height_in = {height_ff[7:0], data_byte};
               end else if (pos_ff == marker_ff + jts_pkg::POS_W'(7)
                            || pos_ff == marker_ff + jts_pkg::POS_W'(8)) begin
                  width_in = {width_ff[7:0], data_byte};
               end
            end
         endcase
      end
   end

   // Form the end-of-frame result from the updated state
   always_comb begin
      result = '0;
      if (too_long) begin
         result.status = jts_pkg::ST_TOO_LONG;
      end else begin
         if (phase_in != jts_pkg::PH_SEEK_FIRST) begin
            result.first_table_offset = first_ofs_in;
         end
         if (phase_in == jts_pkg::PH_SEEK_SOF || phase_in == jts_pkg::PH_SOF_FOUND) begin
            result.second_table_offset = second_ofs_in;
         end
         case (phase_in)
            jts_pkg::PH_SEEK_FIRST:  result.status = jts_pkg::ST_NO_FIRST;
            jts_pkg::PH_SEEK_SECOND: result.status = jts_pkg::ST_NO_SECOND;
            jts_pkg::PH_SEEK_SOF:    result.status = jts_pkg::ST_NO_SIZE;
            default: begin
               if (pos_ff >= marker_in + jts_pkg::POS_W'(8)) begin
                  result.status = jts_pkg::ST_OK;
                  result.image_width = width_in;
                  result.image_height = height_in;
               end else begin
                  result.status = jts_pkg::ST_NO_SIZE;
               end
            end
         endcase
      end
   end

   assign result_valid = take && last_byte;

   // Hold state between transactions, clear it after the last byte
   always_ff @(posedge clock) begin
      if (reset || (take && last_byte)) begin
         pos_ff <= '0;
         prev_byte_ff <= '0;
         prev_valid_ff <= 1'b0;
         phase_ff <= jts_pkg::PH_SEEK_FIRST;
         resume_ff <= '0;
         marker_ff <= '0;
         len_high_ff <= '0;
         first_ofs_ff <= '0;
         second_ofs_ff <= '0;
         width_ff <= '0;
         height_ff <= '0;
      end else if (take) begin
         pos_ff <= pos_in;
         prev_byte_ff <= prev_byte_in;
         prev_valid_ff <= prev_valid_in;
         phase_ff <= phase_in;
         resume_ff <= resume_in;
         marker_ff <= marker_in;
         len_high_ff <= len_high_in;
         first_ofs_ff <= first_ofs_in;
         second_ofs_ff <= second_ofs_in;
         width_ff <= width_in;
         height_ff <= height_in;
      end
   end

endmodule

// ===== rtl/core/jts_out_buf.sv =====
// Two-entry result buffer: an output register plus a skid register, so the
// scan side keeps taking bytes while a result waits. Depends on jts_pkg.
module jts_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  jts_pkg::result_type  push_data,
   output logic                 push_ready,
   output logic                 out_valid,
   input  logic                 out_ready,
   output jts_pkg::result_type  out_data
);

   logic                head_valid_ff, head_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   jts_pkg::result_type head_ff, head_in;
   jts_pkg::result_type skid_ff, skid_in;
   logic                pop;

   assign pop = head_valid_ff && out_ready;
   assign push_ready = !skid_valid_ff;

   // Refill the head from the skid first, park a new result in the skid if blocked
   always_comb begin
      head_valid_in = head_valid_ff;
      skid_valid_in = skid_valid_ff;
      head_in = head_ff;
      skid_in = skid_ff;
      if (!head_valid_ff || pop) begin
         if (skid_valid_ff) begin
            head_in = skid_ff;
            head_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            head_in = push_data;
            head_valid_in = push;
         end
      end else if (push) begin
         skid_in = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   assign out_valid = head_valid_ff;
   assign out_data = head_ff;

endmodule

// ===== rtl/core/jpeg_table_and_size_scanner_top.sv =====
// Top level of the JPEG table and size scanner: byte scan plus result buffer.
// Depends on jts_pkg, jts_req_if, jts_rsp_if, jts_scan and jts_out_buf.
//
//   channel   dir   transaction
//   req_bus   in    data_byte[7:0], last_byte
//   rsp_bus   out   status[2:0], first/second_table_offset[20:0],
//                   image_width[15:0], image_height[15:0]
//
// One byte per cycle; the result of a frame enters the result buffer when its
// last byte is taken. The byte scan is a single register stage; the rate is
// set by the two-entry result buffer, which refuses bytes only while both
// entries hold results. Reset (synchronous) clears the scan state and empties
// the buffer; the state also clears itself after every last byte.
module jpeg_table_and_size_scanner_top (
   input  logic    clock,
   input  logic    reset,
   jts_req_if.sink req_bus,
   jts_rsp_if.source rsp_bus
);

   logic                take;
   logic                push_ready;
   logic                result_valid;
   jts_pkg::result_type result;
   jts_pkg::result_type out_data;

   assign req_bus.ready = push_ready;
   assign take = req_bus.valid && push_ready;

   // Scan one byte per accepted transaction
   jts_scan u_scan (
      .clock        (clock),
      .reset        (reset),
      .take         (take),
      .data_byte    (req_bus.data_byte),
      .last_byte    (req_bus.last_byte),
      .result_valid (result_valid),
      .result       (result)
   );

   // Buffer frame results toward the output
   jts_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (result_valid),
      .push_data  (result),
      .push_ready (push_ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_data   (out_data)
   );

   assign rsp_bus.status = out_data.status;
   assign rsp_bus.first_table_offset = out_data.first_table_offset;
   assign rsp_bus.second_table_offset = out_data.second_table_offset;
   assign rsp_bus.image_width = out_data.image_width;
   assign rsp_bus.image_height = out_data.image_height;

   // An empty buffer never refuses bytes
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_bus.valid |-> req_bus.ready)
      else $error("input stalled with an empty result buffer");

   // A result only appears after a last byte was taken
   a_result_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(req_bus.valid && req_bus.ready && req_bus.last_byte))
      else $error("result appeared without a last byte");

   // A good frame always carries both table offsets
   a_ok_has_offsets: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == jts_pkg::ST_OK)
      |-> (rsp_bus.first_table_offset != '0 && rsp_bus.second_table_offset != '0))
      else $error("ok status with a missing table offset");

   // An overlong frame reports nothing but its status
   a_too_long_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.status == jts_pkg::ST_TOO_LONG)
      |-> (rsp_bus.first_table_offset == '0 && rsp_bus.image_width == '0
           && rsp_bus.image_height == '0))
      else $error("overlong frame reported offsets or size");

endmodule

// ===== sim/tb_jpeg_table_and_size_scanner_top.sv =====
`timescale 1ns / 1ps
// Testbench for jpeg_table_and_size_scanner_top: directed frames checked against the
// table, then random frames under several idle/stall mixes checked against a scan
// predictor. Depends on jts_pkg, jts_req_if, jts_rsp_if and the scanner RTL.
module tb_jpeg_table_and_size_scanner_top;

   localparam int unsigned CYCLE_LIMIT = 100000;
   localparam int unsigned DRAIN_CYCLES = 10;
   localparam int unsigned ITEMS_PER_PHASE = 225;

   localparam jts_pkg::result_type R_NO_FIRST =
      '{jts_pkg::ST_NO_FIRST, 21'd0, 21'd0, 16'd0, 16'd0};
   localparam jts_pkg::result_type R_FIRST_ONLY =
      '{jts_pkg::ST_NO_SECOND, 21'd5, 21'd0, 16'd0, 16'd0};
   localparam jts_pkg::result_type R_FULL =
      '{jts_pkg::ST_OK, 21'd5, 21'd9, 16'hFFFF, 16'hFFFF};
   localparam jts_pkg::result_type R_NONE = '0;

   typedef struct {
      logic [7:0]          data_byte;
      logic                last_byte;
      bit                  typed;
      jts_pkg::result_type want;
   } stim_row_type;

   // Directed frames: lone bytes, a marker split across frames, a marker ending
   // the frame, a marker inside the pending length, and a minimal complete frame
   // with a short length and all-ones sizes.
   stim_row_type dir_rows [26] = '{
      '{8'h00, 1'b1, 1'b1, R_NO_FIRST},
      '{8'hFF, 1'b1, 1'b1, R_NO_FIRST},
      '{8'hDB, 1'b1, 1'b1, R_NO_FIRST},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hDB, 1'b1, 1'b1, R_FIRST_ONLY},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hDB, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hDB, 1'b1, 1'b1, R_FIRST_ONLY},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hDB, 1'b0, 1'b0, R_NONE},
      '{8'h00, 1'b0, 1'b0, R_NONE},
      '{8'h00, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hDB, 1'b0, 1'b0, R_NONE},
      '{8'h00, 1'b0, 1'b0, R_NONE},
      '{8'h02, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hC0, 1'b0, 1'b0, R_NONE},
      '{8'h00, 1'b0, 1'b0, R_NONE},
      '{8'h11, 1'b0, 1'b0, R_NONE},
      '{8'h22, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b0, 1'b0, R_NONE},
      '{8'hFF, 1'b1, 1'b1, R_FULL}
   };

   int unsigned src_plan [4] = '{0, 82, 0, 26};
   int unsigned snk_plan [4] = '{0, 0, 82, 26};

   logic clock = 1'b0;
   logic reset;

   jts_req_if req_bus ();
   jts_rsp_if rsp_bus ();

   jpeg_table_and_size_scanner_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor state: a private copy of the scanner registers.
   logic [jts_pkg::POS_W-1:0] scan_pos;
   logic [7:0]                prev_byte;
   logic                      prev_ok;
   logic [1:0]                phase;
   logic [jts_pkg::POS_W-1:0] resume_pos;
   logic [jts_pkg::POS_W-1:0] mark_pos;
   logic [7:0]                len_hi;
   logic [jts_pkg::OFS_W-1:0] first_ofs;
   logic [jts_pkg::OFS_W-1:0] second_ofs;
   logic [jts_pkg::DIM_W-1:0] width_acc;
   logic [jts_pkg::DIM_W-1:0] height_acc;

   jts_pkg::result_type frame_reports [$];
   logic [7:0]          frame_bytes [$];
   int unsigned         src_idle_pct;
   int unsigned         snk_stall_pct;
   int unsigned         items_sent;
   int unsigned         fail_count = 0;
   int unsigned         cycle_count = 0;

   function automatic void clear_scan();
      scan_pos = '0;
      prev_byte = '0;
      prev_ok = 1'b0;
      phase = jts_pkg::PH_SEEK_FIRST;
      resume_pos = '0;
      mark_pos = '0;
      len_hi = '0;
      first_ofs = '0;
      second_ofs = '0;
      width_acc = '0;
      height_acc = '0;
   endfunction

   // Capture the two length bytes after a marker; they are never part of a pair match.
   function automatic bit take_length(input logic [jts_pkg::POS_W-1:0] pos,
                                      input logic [7:0] d);
      logic [15:0] seg_len;
      if (32'(pos) == 32'(mark_pos) + 2) begin
         len_hi = d;
         return 1'b1;
      end
      if (32'(pos) == 32'(mark_pos) + 3) begin
         seg_len = {len_hi, d};
         if (seg_len < jts_pkg::MIN_SEG_LEN)
            seg_len = jts_pkg::MIN_SEG_LEN;
         resume_pos = mark_pos + jts_pkg::POS_W'(seg_len);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Advance the predictor by one byte; on the last byte produce the frame report.
   function automatic void scan_byte(input logic [7:0] d, input logic lst,
                                     output bit emit, output jts_pkg::result_type res);
      logic [jts_pkg::POS_W-1:0] pos;
      logic [jts_pkg::POS_W-1:0] cand;
      logic [15:0]               word;
      bit                        past_limit;
      bit                        pair_ok;
      emit = 1'b0;
      res = '0;
      pos = scan_pos;
      past_limit = (pos >= jts_pkg::FRAME_LIMIT);
      if (!past_limit) begin
         word = {d, prev_byte};
         cand = pos - 1'b1;
         pair_ok = prev_ok && (pos >= 1) && (cand >= resume_pos);
         case (phase)
            jts_pkg::PH_SEEK_FIRST: begin
               if (pair_ok && word == {jts_pkg::DQT_CODE, jts_pkg::MARK_PREFIX}) begin
                  mark_pos = cand;
                  first_ofs = jts_pkg::OFS_W'(cand + jts_pkg::POS_W'(5));
                  resume_pos = cand + jts_pkg::POS_W'(4);
                  phase = jts_pkg::PH_SEEK_SECOND;
               end
            end
            jts_pkg::PH_SEEK_SECOND: begin
               if (!take_length(pos, d) && pair_ok
                   && word == {jts_pkg::DQT_CODE, jts_pkg::MARK_PREFIX}) begin
                  mark_pos = cand;
                  second_ofs = jts_pkg::OFS_W'(cand + jts_pkg::POS_W'(5));
                  resume_pos = cand + jts_pkg::POS_W'(4);
                  phase = jts_pkg::PH_SEEK_SOF;
               end
            end
            jts_pkg::PH_SEEK_SOF: begin
               if (!take_length(pos, d) && pair_ok
                   && word == {jts_pkg::SOF0_CODE, jts_pkg::MARK_PREFIX}) begin
                  mark_pos = cand;
                  phase = jts_pkg::PH_SOF_FOUND;
               end
            end
            default: begin
               if (32'(pos) == 32'(mark_pos) + 5 || 32'(pos) == 32'(mark_pos) + 6)
                  height_acc = {height_acc[7:0], d};
               else if (32'(pos) == 32'(mark_pos) + 7 || 32'(pos) == 32'(mark_pos) + 8)
                  width_acc = {width_acc[7:0], d};
            end
         endcase
         scan_pos = pos + 1'b1;
         prev_byte = d;
         prev_ok = 1'b1;
      end
      if (lst) begin
         emit = 1'b1;
         if (past_limit) begin
            res.status = jts_pkg::ST_TOO_LONG;
         end else begin
            if (phase != jts_pkg::PH_SEEK_FIRST)
               res.first_table_offset = first_ofs;
            if (phase == jts_pkg::PH_SEEK_SOF || phase == jts_pkg::PH_SOF_FOUND)
               res.second_table_offset = second_ofs;
            case (phase)
               jts_pkg::PH_SEEK_FIRST:  res.status = jts_pkg::ST_NO_FIRST;
               jts_pkg::PH_SEEK_SECOND: res.status = jts_pkg::ST_NO_SECOND;
               jts_pkg::PH_SEEK_SOF:    res.status = jts_pkg::ST_NO_SIZE;
               default: begin
                  if (32'(pos) >= 32'(mark_pos) + 8) begin
                     res.status = jts_pkg::ST_OK;
                     res.image_width = width_acc;
                     res.image_height = height_acc;
                  end else begin
                     res.status = jts_pkg::ST_NO_SIZE;
                  end
               end
            endcase
         end
         clear_scan();
      end
   endfunction

   // Offer one byte, idling first at random; on acceptance queue its report, if any.
   task automatic send_byte(input logic [7:0] d, input logic lst, input bit typed,
                            input jts_pkg::result_type typed_report);
      bit                  emit;
      jts_pkg::result_type res;
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= d;
      req_bus.last_byte <= lst;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
      scan_byte(d, lst, emit, res);
      if (emit)
         frame_reports.push_back(typed ? typed_report : res);
   endtask

   // Hold the input idle until every report has come, then let the block settle.
   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (frame_reports.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic void push_filler(input int unsigned n);
      repeat (n) frame_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void push_marker(input logic [7:0] code);
      frame_bytes.push_back(jts_pkg::MARK_PREFIX);
      frame_bytes.push_back(code);
   endfunction

   // Table marker, length (often short), then filler up to or just around the
   // point where the next search may start.
   function automatic void push_table_segment();
      logic [15:0] seg;
      int unsigned span;
      push_marker(jts_pkg::DQT_CODE);
      seg = ($urandom_range(3) == 0) ? 16'($urandom_range(5)) : 16'($urandom_range(4, 14));
      frame_bytes.push_back(seg[15:8]);
      frame_bytes.push_back(seg[7:0]);
      span = (seg < jts_pkg::MIN_SEG_LEN) ? 0 : seg - 4;
      if (span > 0 && $urandom_range(9) == 0)
         span--;
      else
         span += $urandom_range(2);
      push_filler(span);
   endfunction

   // Mostly well-formed frames with random content, some cut short; the rest
   // marker-heavy noise or a table marker sitting in its own length bytes.
   function automatic void build_frame();
      int unsigned kind;
      int unsigned keep;
      frame_bytes.delete();
      kind = $urandom_range(99);
      push_filler($urandom_range(3));
      if (kind < 70) begin
         repeat (2) push_table_segment();
         push_marker(jts_pkg::SOF0_CODE);
         push_filler(7);
         push_filler($urandom_range(3));
         if ($urandom_range(3) == 0) begin
            keep = $urandom_range(1, frame_bytes.size());
            frame_bytes = frame_bytes[0:keep-1];
         end
      end else if (kind < 85) begin
         repeat ($urandom_range(1, 20)) begin
            case ($urandom_range(3))
               0: frame_bytes.push_back(jts_pkg::MARK_PREFIX);
               1: frame_bytes.push_back(jts_pkg::DQT_CODE);
               2: frame_bytes.push_back(jts_pkg::SOF0_CODE);
               default: frame_bytes.push_back(8'($urandom_range(255)));
            endcase
         end
      end else begin
         push_marker(jts_pkg::DQT_CODE);
         push_marker(jts_pkg::DQT_CODE);
         push_filler($urandom_range(6));
      end
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
         fail_count++;
      end
   endtask

   // Check each result transaction against the oldest report; drive ready at random.
   always @(posedge clock) begin
      jts_pkg::result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (frame_reports.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual status %0h", $time,
                     rsp_bus.status);
            fail_count++;
         end else begin
            want = frame_reports.pop_front();
            compare_field("status", 32'(want.status), 32'(rsp_bus.status));
            compare_field("first_table_offset", 32'(want.first_table_offset),
                          32'(rsp_bus.first_table_offset));
            compare_field("second_table_offset", 32'(want.second_table_offset),
                          32'(rsp_bus.second_table_offset));
            compare_field("image_width", 32'(want.image_width),
                          32'(rsp_bus.image_width));
            compare_field("image_height", 32'(want.image_height),
                          32'(rsp_bus.image_height));
         end
      end
      rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      int unsigned phase_start;
      clear_scan();
      src_idle_pct = 0;
      snk_stall_pct = 0;
      items_sent = 0;
      reset <= 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= 8'h00;
      req_bus.last_byte <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      foreach (dir_rows[i])
         send_byte(dir_rows[i].data_byte, dir_rows[i].last_byte, dir_rows[i].typed,
                   dir_rows[i].want);
      wait_drained();

      // Random frames, one idle/stall mix per phase; drain fully between phases.
      for (int p = 0; p < 4; p++) begin
         src_idle_pct = src_plan[p];
         snk_stall_pct = snk_plan[p];
         phase_start = items_sent;
         while (items_sent - phase_start < ITEMS_PER_PHASE) begin
            build_frame();
            foreach (frame_bytes[i])
               send_byte(frame_bytes[i], i == frame_bytes.size() - 1, 1'b0, R_NONE);
         end
         wait_drained();
      end

      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
